// File: hdl/xeu_pkg.sv
// Shared types and constants for the XML character entity decoder.
// No dependencies; used by xeu_decode and xml_entity_unescape_utf8_top.
package xeu_pkg;

  // Largest number of results one input byte can cause (7-byte UTF-8 form)
  localparam int MaxResults = 7;
  localparam int CountW     = $clog2(MaxResults + 1);

  // Parser modes, one-hot
  typedef enum logic [6:0] {
    MODE_TEXT = 7'b000_0001,
    MODE_NAME = 7'b000_0010,
    MODE_HASH = 7'b000_0100,
    MODE_DEC  = 7'b000_1000,
    MODE_HEX  = 7'b001_0000,
    MODE_BAD  = 7'b010_0000,
    MODE_DROP = 7'b100_0000
  } mode_t;

  typedef enum logic [1:0] {
    ST_DATA         = 2'd0,
    ST_MISSING_SEMI = 2'd1,
    ST_INVALID      = 2'd2
  } status_t;

  // Characters the parser looks for
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LT   = 8'h3C;

  // Entity names, newest byte lowest
  localparam logic [23:0] NAME_GT  = 24'h006774;
  localparam logic [23:0] NAME_LT  = 24'h006C74;
  localparam logic [23:0] NAME_AMP = 24'h616D70;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
    logic       string_end;
  } out_t;

  // Results of one input byte, first result in the low byte
  typedef struct packed {
    logic [8*MaxResults-1:0] bytes;
    logic [CountW-1:0]       count;
    status_t                 status;
    logic                    str_end;
  } burst_t;

endpackage

// File: hdl/xeu_decode.sv
// Entity parser state and the decode of one byte into its group of results.
// Depends on xeu_pkg.
module xeu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  xeu_pkg::in_t    item,
  output xeu_pkg::burst_t burst
);

  xeu_pkg::mode_t mode, mode_next;
  logic [31:0] code_value, code_value_next;
  logic        value_overflow, value_overflow_next;
  logic [23:0] name_chars, name_chars_next;
  logic [2:0]  name_length, name_length_next;

  logic [7:0]  b;
  logic [3:0]  dig;
  logic        dig_dec, dig_hex, dig_ok;
  logic [35:0] acc;
  logic        err, utf_go;
  logic [31:0] utf_val;
  logic [2:0]  extra;
  logic [35:0] utf_wide;
  logic [7:0]  cont [6];
  logic [7:0]  ub [xeu_pkg::MaxResults];
  logic [2:0]  cidx;

  assign b = item.in_byte;

  always_comb begin
    dig_dec = (b >= 8'h30) && (b <= 8'h39);
    dig_hex = 1'b0;
    dig     = b[3:0];
    if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      dig_hex = 1'b1;
      dig     = 4'(b[3:0] + 4'd9);
    end
    dig_ok = dig_dec || (dig_hex && mode == xeu_pkg::MODE_HEX);
    if (mode == xeu_pkg::MODE_HEX) acc = {code_value, 4'b0} + 36'(dig);
    else acc = {1'b0, code_value, 3'b0} + {3'b0, code_value, 1'b0} + 36'(dig);
  end

  always_comb begin
    mode_next           = mode;
    code_value_next     = code_value;
    value_overflow_next = value_overflow;
    name_chars_next     = name_chars;
    name_length_next    = name_length;
    burst               = '0;
    burst.status        = xeu_pkg::ST_DATA;
    err                 = 1'b0;
    utf_go              = 1'b0;
    utf_val             = '0;

    unique case (mode)
      xeu_pkg::MODE_NAME: begin
        if (b == xeu_pkg::CH_SEMI) begin
          mode_next = xeu_pkg::MODE_TEXT;
          burst.count = xeu_pkg::CountW'(1);
          if (name_length == 3'd2 && name_chars == xeu_pkg::NAME_GT)
            burst.bytes[7:0] = xeu_pkg::CH_GT;
          else if (name_length == 3'd2 && name_chars == xeu_pkg::NAME_LT)
            burst.bytes[7:0] = xeu_pkg::CH_LT;
          else if (name_length == 3'd3 && name_chars == xeu_pkg::NAME_AMP)
            burst.bytes[7:0] = xeu_pkg::CH_AMP;
          else err = 1'b1;
        end else if (name_length == 3'd0 && b == xeu_pkg::CH_HASH) begin
          mode_next = xeu_pkg::MODE_HASH;
        end else begin
          name_chars_next = {name_chars[15:0], b};
          if (name_length < 3'd4) name_length_next = name_length + 3'd1;
        end
      end
      xeu_pkg::MODE_HASH: begin
        if (b == xeu_pkg::CH_SEMI) begin
          utf_go    = 1'b1;
          mode_next = xeu_pkg::MODE_TEXT;
        end else if (b == xeu_pkg::CH_X) begin
          mode_next = xeu_pkg::MODE_HEX;
        end else if (dig_dec) begin
          code_value_next = {28'b0, dig};
          mode_next       = xeu_pkg::MODE_DEC;
        end else begin
          mode_next = xeu_pkg::MODE_BAD;
        end
      end
      xeu_pkg::MODE_DEC, xeu_pkg::MODE_HEX: begin
        if (b == xeu_pkg::CH_SEMI) begin
          if (value_overflow) err = 1'b1;
          else begin
            utf_go  = 1'b1;
            utf_val = code_value;
          end
          mode_next = xeu_pkg::MODE_TEXT;
        end else if (dig_ok) begin
          code_value_next = acc[31:0];
          if (acc[35:32] != 4'd0) value_overflow_next = 1'b1;
        end else begin
          mode_next = xeu_pkg::MODE_BAD;
        end
      end
      xeu_pkg::MODE_BAD: begin
        if (b == xeu_pkg::CH_SEMI) begin
          err       = 1'b1;
          mode_next = xeu_pkg::MODE_TEXT;
        end
      end
      xeu_pkg::MODE_DROP: ;
      default: begin
        if (b == xeu_pkg::CH_AMP) begin
          mode_next = xeu_pkg::MODE_NAME;
        end else begin
          burst.bytes[7:0] = b;
          burst.count      = xeu_pkg::CountW'(1);
        end
      end
    endcase

    // UTF-8 form of a numeric entity
    if (utf_val < 32'h80)            extra = 3'd0;
    else if (utf_val < 32'h800)      extra = 3'd1;
    else if (utf_val < 32'h10000)    extra = 3'd2;
    else if (utf_val < 32'h200000)   extra = 3'd3;
    else if (utf_val < 32'h4000000)  extra = 3'd4;
    else if (utf_val < 32'h80000000) extra = 3'd5;
    else                             extra = 3'd6;
    utf_wide = {4'b0, utf_val};
    for (int j = 0; j < 6; j++) cont[j] = {2'b10, utf_wide[6*j +: 6]};
    for (int k = 0; k < xeu_pkg::MaxResults; k++) begin
      cidx  = 3'(int'(extra) - k);
      ub[k] = 8'h00;
      if (k == 0) begin
        unique case (extra)
          3'd0:    ub[k] = {1'b0, utf_val[6:0]};
          3'd1:    ub[k] = {3'b110, utf_val[10:6]};
          3'd2:    ub[k] = {4'b1110, utf_val[15:12]};
          3'd3:    ub[k] = {5'b11110, utf_val[20:18]};
          3'd4:    ub[k] = {6'b111110, utf_val[25:24]};
          3'd5:    ub[k] = {7'b1111110, utf_val[30]};
          default: ub[k] = 8'hFE;
        endcase
      end else if (k <= int'(extra) && cidx < 3'd6) begin
        ub[k] = cont[cidx];
      end
    end
    if (utf_go) begin
      for (int k = 0; k < xeu_pkg::MaxResults; k++) burst.bytes[8*k +: 8] = ub[k];
      burst.count = xeu_pkg::CountW'(extra) + 1'b1;
    end

    if (err) begin
      burst.bytes  = '0;
      burst.count  = xeu_pkg::CountW'(1);
      burst.status = xeu_pkg::ST_INVALID;
      mode_next    = xeu_pkg::MODE_DROP;
    end

    if (mode_next == xeu_pkg::MODE_TEXT || mode_next == xeu_pkg::MODE_DROP
        || (mode == xeu_pkg::MODE_TEXT && b == xeu_pkg::CH_AMP)) begin
      code_value_next     = '0;
      value_overflow_next = 1'b0;
      name_chars_next     = '0;
      name_length_next    = '0;
    end

    if (item.in_last) begin
      // string ends inside an entity: report the missing semicolon
      if (mode_next != xeu_pkg::MODE_TEXT && mode_next != xeu_pkg::MODE_DROP) begin
        burst.bytes  = '0;
        burst.count  = xeu_pkg::CountW'(1);
        burst.status = xeu_pkg::ST_MISSING_SEMI;
      end
      burst.str_end       = 1'b1;
      mode_next           = xeu_pkg::MODE_TEXT;
      code_value_next     = '0;
      value_overflow_next = 1'b0;
      name_chars_next     = '0;
      name_length_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= xeu_pkg::MODE_TEXT;
      code_value     <= '0;
      value_overflow <= 1'b0;
      name_chars     <= '0;
      name_length    <= '0;
    end else if (adv) begin
      mode           <= mode_next;
      code_value     <= code_value_next;
      value_overflow <= value_overflow_next;
      name_chars     <= name_chars_next;
      name_length    <= name_length_next;
    end
  end

endmodule

// File: hdl/xml_entity_unescape_utf8_top.sv
// XML character entity decoder, UTF-8 output.
// An accepted byte goes to the item register, its results to the result register.
// Throughput: one input byte per cycle while out_stall is low and each byte gives
// at most one result; more results hold the result register until all are taken.
// Reset clears the parser to plain text mode and drops any pending results.
// Depends on xeu_pkg and xeu_decode.
module xml_entity_unescape_utf8_top (
  input  logic         clk,
  input  logic         rst,
  input  xeu_pkg::in_t  in_data,
  input  logic         in_valid,
  output logic         in_stall,
  output xeu_pkg::out_t out_data,
  output logic         out_valid,
  input  logic         out_stall
);

  xeu_pkg::in_t    item;
  logic            item_valid;
  xeu_pkg::burst_t dec_burst;
  logic            adv, burst_free;

  logic [8*xeu_pkg::MaxResults-1:0] bytes;
  logic [xeu_pkg::CountW-1:0]       left;
  xeu_pkg::status_t                 status;
  logic                             str_end;

  assign out_valid  = (left != '0);
  assign burst_free = (left == '0) || (left == xeu_pkg::CountW'(1) && !out_stall);
  assign adv        = item_valid && burst_free;
  assign in_stall   = item_valid && !adv;

  xeu_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .item  (item),
    .burst (dec_burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (adv) begin
      left <= dec_burst.count;
    end else if (out_valid && !out_stall) begin
      left <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bytes   <= dec_burst.bytes;
      status  <= dec_burst.status;
      str_end <= dec_burst.str_end;
    end else if (out_valid && !out_stall) begin
      bytes <= {8'h00, bytes[8*xeu_pkg::MaxResults-1:8]};
    end
  end

  always_comb begin
    out_data.out_byte   = bytes[7:0];
    out_data.status     = status;
    out_data.run_last   = (left == xeu_pkg::CountW'(1));
    out_data.string_end = str_end && (left == xeu_pkg::CountW'(1));
  end

endmodule
